// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands for the linked-list queue buffer.
// They sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cons holds in the same cycle as ante.
`define LLMQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("llmq check failed");

// Checks that cons holds in the cycle after ante.
`define LLMQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("llmq check failed");

`endif

// ===== sv/llmq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llmq_pkg
// Shared constants, payload types, memory request types and controller
// states for the linked-list multi-queue buffer.
// ----------------------------------------------------------------------------
package llmq_pkg;

    localparam int NODE_BYTES  = 64;
    localparam int NODE_COUNT  = 128;
    localparam int LIST_COUNT  = 7;
    localparam int FREE_LIST   = 0;

    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int OFS_W       = $clog2(NODE_BYTES);
    localparam int DADDR_W     = NODE_W + OFS_W;
    localparam int DATA_DEPTH  = NODE_COUNT * (1 << OFS_W);
    localparam int CNT_W       = $clog2(NODE_BYTES + 1);
    localparam int LIDX_W      = $clog2(LIST_COUNT);
    localparam int QID_W       = 3;
    localparam int LEN_W       = 7;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_STORED = 3'd0,
        ST_READ   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_DROP   = 3'd3,
        ST_BADQ   = 3'd4
    } status_t;

    typedef struct packed {
        opcode_t            opcode;
        logic [QID_W-1:0]   queue_id;
        logic [7:0]         data_in;
        logic               last_in;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [7:0]         data_out;
        logic               last_out;
        logic [LEN_W-1:0]   node_length;
    } res_t;

    typedef struct packed {
        logic               emit;
        res_t               res;
    } res_push_t;

    typedef struct packed {
        logic               we;
        logic [DADDR_W-1:0] waddr;
        logic [7:0]         wdata;
        logic [DADDR_W-1:0] raddr;
    } data_req_t;

    typedef struct packed {
        logic               we;
        logic [NODE_W-1:0]  waddr;
        logic [NODE_W-1:0]  wdata;
        logic [NODE_W-1:0]  raddr;
    } link_req_t;

    typedef struct packed {
        logic               we;
        logic [NODE_W-1:0]  waddr;
        logic [CNT_W-1:0]   wdata;
        logic [NODE_W-1:0]  raddr;
    } fill_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_OP,
        S_WPOP,
        S_WSTORE,
        S_RPOP,
        S_RADDR,
        S_RDATA,
        S_RFREE,
        S_EMIT
    } state_t;

    // Reset chaining of the pool: node n links to n+1, last node wraps to 0.
    function automatic logic [NODE_W-1:0] node_succ(input logic [NODE_W-1:0] n);
        if (n == NODE_W'(NODE_COUNT - 1))
            return '0;
        else
            return n + NODE_W'(1);
    endfunction

endpackage

// ===== sv/llmq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llmq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module llmq_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/llmq_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llmq_out
// Result output register. Holds one result until its transfer completes
// and reports when the controller may load the next one.
// ----------------------------------------------------------------------------
module llmq_out (
    input  logic              clk,
    input  logic              rst_n,
    input  llmq_pkg::res_push_t push,
    output logic              free,
    output logic              res_valid,
    input  logic              res_stall,
    output llmq_pkg::res_t    res
);
    import llmq_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;
    res_t res_next;

    assign free = !valid_reg || !res_stall;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (push.emit)
        begin
            valid_next = 1'b1;
            res_next   = push.res;
        end
        else if (!res_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

// ===== sv/llmq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llmq_ctrl
// Queue manager sequencer: list head/tail registers, open node tracking,
// and reads and writes of the link, fill and byte memories.
// ----------------------------------------------------------------------------
module llmq_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  llmq_pkg::cmd_t              cmd,
    output llmq_pkg::data_req_t         data_req,
    input  logic [7:0]                  data_rdata,
    output llmq_pkg::link_req_t         link_req,
    input  logic [llmq_pkg::NODE_W-1:0] link_rdata,
    output llmq_pkg::fill_req_t         fill_req,
    input  logic [llmq_pkg::CNT_W-1:0]  fill_rdata,
    output llmq_pkg::res_push_t         push,
    input  logic                        out_free
);
    import llmq_pkg::*;

    localparam logic [LIDX_W-1:0] FREE_IDX = LIDX_W'(FREE_LIST);

    state_t             state_reg,   state_next;
    cmd_t               cmd_reg,     cmd_next;
    logic [NODE_W-1:0]  head_reg     [LIST_COUNT];
    logic [NODE_W-1:0]  head_next    [LIST_COUNT];
    logic [NODE_W-1:0]  tail_reg     [LIST_COUNT];
    logic [NODE_W-1:0]  tail_next    [LIST_COUNT];
    logic [LIST_COUNT-1:0] nonempty_reg, nonempty_next;
    logic [NODE_COUNT-1:0] link_vld_reg, link_vld_next;
    logic [NODE_W-1:0]  open_node_reg, open_node_next;
    logic [CNT_W-1:0]   open_cnt_reg,  open_cnt_next;
    logic [LIDX_W-1:0]  open_q_reg,    open_q_next;
    logic               drop_reg,      drop_next;
    logic [NODE_W-1:0]  rnode_reg,     rnode_next;
    logic [CNT_W-1:0]   rlen_reg,      rlen_next;
    logic [CNT_W-1:0]   ridx_reg,      ridx_next;
    res_t               pend_reg,      pend_next;

    logic [LIDX_W-1:0]  qi;
    logic               bad_q;
    logic [LIDX_W-1:0]  opsel;
    logic [NODE_W-1:0]  pop_head;
    logic [NODE_W-1:0]  pop_tail;
    logic [NODE_W-1:0]  link_val;
    logic [CNT_W-1:0]   fill_len;
    logic [CNT_W-1:0]   cnt_inc;
    logic [CNT_W-1:0]   ridx_inc;
    logic               push_en;
    logic [LIDX_W-1:0]  push_list;
    logic [NODE_W-1:0]  push_node;

    assign qi       = cmd_reg.queue_id[LIDX_W-1:0];
    assign bad_q    = (cmd_reg.queue_id == '0)
                   || ({1'b0, cmd_reg.queue_id} >= (QID_W+1)'(LIST_COUNT));
    assign opsel    = (cmd_reg.opcode == OP_WRITE) ? FREE_IDX : qi;
    assign pop_head = head_reg[opsel];
    assign pop_tail = tail_reg[opsel];
    assign link_val = link_vld_reg[pop_head] ? link_rdata : node_succ(pop_head);
    assign fill_len = (fill_rdata == '0 || fill_rdata > CNT_W'(NODE_BYTES))
                    ? CNT_W'(NODE_BYTES) : fill_rdata;
    assign cnt_inc  = open_cnt_reg + CNT_W'(1);
    assign ridx_inc = ridx_reg + CNT_W'(1);
    assign cmd_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        nonempty_next  = nonempty_reg;
        link_vld_next  = link_vld_reg;
        open_node_next = open_node_reg;
        open_cnt_next  = open_cnt_reg;
        open_q_next    = open_q_reg;
        drop_next      = drop_reg;
        rnode_next     = rnode_reg;
        rlen_next      = rlen_reg;
        ridx_next      = ridx_reg;
        pend_next      = pend_reg;

        data_req.we    = 1'b0;
        data_req.waddr = {open_node_reg, open_cnt_reg[OFS_W-1:0]};
        data_req.wdata = cmd_reg.data_in;
        data_req.raddr = {rnode_reg, ridx_reg[OFS_W-1:0]};
        link_req.we    = 1'b0;
        link_req.waddr = '0;
        link_req.wdata = '0;
        link_req.raddr = pop_head;
        fill_req.we    = 1'b0;
        fill_req.waddr = open_node_reg;
        fill_req.wdata = open_cnt_reg;
        fill_req.raddr = pop_head;
        push.emit      = 1'b0;
        push.res       = pend_reg;
        push_en        = 1'b0;
        push_list      = open_q_reg;
        push_node      = open_node_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (bad_q)
                begin
                    pend_next  = '{status: ST_BADQ, data_out: '0, last_out: 1'b1,
                                   node_length: '0};
                    state_next = S_EMIT;
                end
                else
                begin
                    // switching queue closes the open node first
                    if (open_q_reg != '0 && open_q_reg != qi)
                    begin
                        if (!drop_reg && open_cnt_reg != '0)
                        begin
                            fill_req.we = 1'b1;
                            push_en     = 1'b1;
                        end
                        open_q_next   = '0;
                        open_cnt_next = '0;
                        drop_next     = 1'b0;
                    end
                    state_next = S_OP;
                end
            end
            S_OP:
            begin
                if (cmd_reg.opcode == OP_WRITE)
                begin
                    if (open_q_reg == '0)
                    begin
                        if (!nonempty_reg[FREE_IDX])
                        begin
                            if (!cmd_reg.last_in)
                            begin
                                open_q_next = qi;
                                drop_next   = 1'b1;
                            end
                            pend_next  = '{status: ST_DROP, data_out: '0, last_out: 1'b1,
                                           node_length: '0};
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_WPOP;
                        end
                    end
                    else if (drop_reg)
                    begin
                        if (cmd_reg.last_in)
                        begin
                            open_q_next = '0;
                            drop_next   = 1'b0;
                        end
                        pend_next  = '{status: ST_DROP, data_out: '0, last_out: 1'b1,
                                       node_length: '0};
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_WSTORE;
                    end
                end
                else
                begin
                    if (!nonempty_reg[qi])
                    begin
                        pend_next  = '{status: ST_EMPTY, data_out: '0, last_out: 1'b1,
                                       node_length: '0};
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_RPOP;
                    end
                end
            end
            S_WPOP:
            begin
                if (pop_head == pop_tail)
                    nonempty_next[opsel] = 1'b0;
                else
                    head_next[opsel] = link_val;
                open_node_next = pop_head;
                open_cnt_next  = '0;
                open_q_next    = qi;
                drop_next      = 1'b0;
                state_next     = S_WSTORE;
            end
            S_WSTORE:
            begin
                data_req.we = 1'b1;
                if (cnt_inc == CNT_W'(NODE_BYTES) || cmd_reg.last_in)
                begin
                    fill_req.we    = 1'b1;
                    fill_req.wdata = cnt_inc;
                    push_en        = 1'b1;
                    open_q_next    = '0;
                    open_cnt_next  = '0;
                    drop_next      = 1'b0;
                end
                else
                begin
                    open_cnt_next = cnt_inc;
                end
                pend_next  = '{status: ST_STORED, data_out: '0, last_out: 1'b1,
                               node_length: '0};
                state_next = S_EMIT;
            end
            S_RPOP:
            begin
                if (pop_head == pop_tail)
                    nonempty_next[opsel] = 1'b0;
                else
                    head_next[opsel] = link_val;
                rnode_next = pop_head;
                rlen_next  = fill_len;
                ridx_next  = '0;
                state_next = S_RADDR;
            end
            S_RADDR:
            begin
                state_next = S_RDATA;
            end
            S_RDATA:
            begin
                if (out_free)
                begin
                    push.emit = 1'b1;
                    push.res  = '{status: ST_READ, data_out: data_rdata,
                                  last_out: (ridx_inc == rlen_reg),
                                  node_length: LEN_W'(rlen_reg)};
                    if (ridx_inc == rlen_reg)
                    begin
                        state_next = S_RFREE;
                    end
                    else
                    begin
                        ridx_next  = ridx_inc;
                        state_next = S_RADDR;
                    end
                end
            end
            S_RFREE:
            begin
                push_en    = 1'b1;
                push_list  = FREE_IDX;
                push_node  = rnode_reg;
                state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    push.emit  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // tail append; never in the same cycle as a pop
        if (push_en)
        begin
            if (nonempty_reg[push_list])
            begin
                link_req.we                   = 1'b1;
                link_req.waddr                = tail_reg[push_list];
                link_req.wdata                = push_node;
                link_vld_next[tail_reg[push_list]] = 1'b1;
                tail_next[push_list]          = push_node;
            end
            else
            begin
                head_next[push_list]     = push_node;
                tail_next[push_list]     = push_node;
                nonempty_next[push_list] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < LIST_COUNT; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            tail_reg[FREE_LIST] <= NODE_W'(NODE_COUNT - 1);
            nonempty_reg  <= LIST_COUNT'(1) << FREE_LIST;
            link_vld_reg  <= '0;
            open_node_reg <= '0;
            open_cnt_reg  <= '0;
            open_q_reg    <= '0;
            drop_reg      <= 1'b0;
            ridx_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            nonempty_reg  <= nonempty_next;
            link_vld_reg  <= link_vld_next;
            open_node_reg <= open_node_next;
            open_cnt_reg  <= open_cnt_next;
            open_q_reg    <= open_q_next;
            drop_reg      <= drop_next;
            ridx_reg      <= ridx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        rnode_reg <= rnode_next;
        rlen_reg  <= rlen_next;
        pend_reg  <= pend_next;
    end

endmodule

// ===== sv/linked_list_multi_queue_buffer.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// linked_list_multi_queue_buffer
// Shared node pool serving six byte FIFO queues through linked lists.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_stall/cmd) carries one command: write one byte
//   to a queue, or read one whole node from a queue. res channel
//   (res_valid/res_stall/res) returns one result per write or failed read,
//   and one result per byte for a successful read; last_out marks the final
//   result of a command.
//   One command is worked on at a time; cmd_stall is high until it is done.
//   A command passes S_CHECK, which ends a bad id, then S_OP, which ends an
//   empty read or dropped write; a stored write passes S_WPOP when a fresh
//   node is taken from the free list, then S_WSTORE; all these emit via S_EMIT.
//   A read passes S_RPOP, then S_RADDR and S_RDATA per byte (registered
//   byte RAM read, one address per byte). The next command is taken in
//   S_IDLE after the last result is loaded; a read first frees its node in S_RFREE.
//   Reset: all queues empty, every node on the free list in index order;
//   no clearing pass is needed, the block takes a command right away.
//   A stalled result holds; the sequencer waits and takes no new command
//   until the result register has room.
// ----------------------------------------------------------------------------
module linked_list_multi_queue_buffer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  llmq_pkg::cmd_t cmd,
    output logic           res_valid,
    input  logic           res_stall,
    output llmq_pkg::res_t res
);
    import llmq_pkg::*;

    data_req_t          data_req;
    link_req_t          link_req;
    fill_req_t          fill_req;
    logic [7:0]         data_rdata;
    logic [NODE_W-1:0]  link_rdata;
    logic [CNT_W-1:0]   fill_rdata;
    res_push_t          push;
    logic               out_free;
    logic               res_single;

    llmq_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_data_ram (
        .clk   (clk),
        .we    (data_req.we),
        .waddr (data_req.waddr),
        .wdata (data_req.wdata),
        .raddr (data_req.raddr),
        .rdata (data_rdata)
    );

    llmq_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_link_ram (
        .clk   (clk),
        .we    (link_req.we),
        .waddr (link_req.waddr),
        .wdata (link_req.wdata),
        .raddr (link_req.raddr),
        .rdata (link_rdata)
    );

    llmq_ram #(.WIDTH(CNT_W), .DEPTH(NODE_COUNT)) u_fill_ram (
        .clk   (clk),
        .we    (fill_req.we),
        .waddr (fill_req.waddr),
        .wdata (fill_req.wdata),
        .raddr (fill_req.raddr),
        .rdata (fill_rdata)
    );

    llmq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .data_req   (data_req),
        .data_rdata (data_rdata),
        .link_req   (link_req),
        .link_rdata (link_rdata),
        .fill_req   (fill_req),
        .fill_rdata (fill_rdata),
        .push       (push),
        .out_free   (out_free)
    );

    llmq_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .free      (out_free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    assign res_single = res_valid && res.status != ST_READ;

    `LLMQ_ASSERT_NXT(a_busy_after_take, cmd_valid && !cmd_stall, cmd_stall)
    `LLMQ_ASSERT_IMP(a_data_wr_busy, data_req.we, cmd_stall)
    `LLMQ_ASSERT_IMP(a_link_wr_busy, link_req.we || fill_req.we, cmd_stall)
    `LLMQ_ASSERT_IMP(a_single_result, res_single, res.last_out && res.node_length == '0)

endmodule

// ===== test/llmq_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llmq_result_checker
// Watches the command and result channels of the linked-list queue buffer.
// It keeps its own copy of the node pool, links and list pointers, predicts
// the results of each accepted command, and compares every result transfer
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module llmq_result_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  logic           cmd_stall,
    input  llmq_pkg::cmd_t cmd,
    input  logic           res_valid,
    input  logic           res_stall,
    input  llmq_pkg::res_t res,
    output int             fail_count,
    output int             pending,
    output int             cmd_count,
    output int             result_count,
    output int             byte_count,
    output int             drop_count
);
    import llmq_pkg::*;

    localparam int POOL_DEPTH = NODE_COUNT * NODE_BYTES;

    logic [7:0]        pool_bytes [POOL_DEPTH];
    logic [NODE_W-1:0] link_of    [NODE_COUNT];
    logic [CNT_W-1:0]  fill_of    [NODE_COUNT];
    logic [NODE_W-1:0] head_of    [LIST_COUNT];
    logic [NODE_W-1:0] tail_of    [LIST_COUNT];
    logic              list_live  [LIST_COUNT];
    logic [NODE_W-1:0] cur_node;
    int                cur_count;
    int                cur_queue;
    logic              dropping;

    res_t              due_results [$];

    function automatic void clear_lists();
        for (int i = 0; i < NODE_COUNT; i++)
            link_of[i] = NODE_W'((i + 1) % NODE_COUNT);
        for (int i = 0; i < LIST_COUNT; i++)
        begin
            head_of[i]   = '0;
            tail_of[i]   = '0;
            list_live[i] = 1'b0;
        end
        tail_of[FREE_LIST]   = NODE_W'(NODE_COUNT - 1);
        list_live[FREE_LIST] = 1'b1;
        cur_node  = '0;
        cur_count = 0;
        cur_queue = 0;
        dropping  = 1'b0;
        due_results.delete();
    endfunction

    function automatic void append_node(input int q, input logic [NODE_W-1:0] n);
        link_of[n] = '0;
        if (list_live[q])
        begin
            link_of[tail_of[q]] = n;
            tail_of[q] = n;
        end
        else
        begin
            head_of[q]   = n;
            tail_of[q]   = n;
            list_live[q] = 1'b1;
        end
    endfunction

    function automatic bit take_node(input int q, output logic [NODE_W-1:0] n);
        n = '0;
        if (!list_live[q])
            return 1'b0;
        n = head_of[q];
        if (n == tail_of[q])
            list_live[q] = 1'b0;
        else
            head_of[q] = link_of[n];
        link_of[n] = '0;
        return 1'b1;
    endfunction

    function automatic void close_open_node();
        if (cur_queue != 0 && !dropping && cur_count > 0)
        begin
            fill_of[cur_node] = CNT_W'(cur_count);
            append_node(cur_queue, cur_node);
        end
        cur_queue = 0;
        cur_count = 0;
        dropping  = 1'b0;
    endfunction

    function automatic void post_result(input status_t s, input logic [7:0] d,
                                        input logic last, input int len);
        res_t r;
        r.status      = s;
        r.data_out    = d;
        r.last_out    = last;
        r.node_length = LEN_W'(len);
        due_results.push_back(r);
    endfunction

    function automatic void run_queue_command(input cmd_t c);
        int                q;
        int                len;
        logic [NODE_W-1:0] n;
        q = int'(c.queue_id);
        if (q == FREE_LIST || q >= LIST_COUNT)
        begin
            post_result(ST_BADQ, 8'h00, 1'b1, 0);
            return;
        end
        if (cur_queue != 0 && cur_queue != q)
            close_open_node();
        if (c.opcode == OP_WRITE)
        begin
            if (cur_queue == 0)
            begin
                if (!take_node(FREE_LIST, n))
                begin
                    if (!c.last_in)
                    begin
                        cur_queue = q;
                        dropping  = 1'b1;
                    end
                    post_result(ST_DROP, 8'h00, 1'b1, 0);
                    return;
                end
                cur_node  = n;
                cur_count = 0;
                cur_queue = q;
                dropping  = 1'b0;
            end
            if (dropping)
            begin
                if (c.last_in)
                begin
                    cur_queue = 0;
                    dropping  = 1'b0;
                end
                post_result(ST_DROP, 8'h00, 1'b1, 0);
                return;
            end
            if (cur_count >= NODE_BYTES)
                cur_count = NODE_BYTES - 1;
            pool_bytes[int'(cur_node) * NODE_BYTES + cur_count] = c.data_in;
            cur_count++;
            if (cur_count >= NODE_BYTES || c.last_in)
                close_open_node();
            post_result(ST_STORED, 8'h00, 1'b1, 0);
        end
        else
        begin
            if (!take_node(q, n))
            begin
                post_result(ST_EMPTY, 8'h00, 1'b1, 0);
                return;
            end
            len = int'(fill_of[n]);
            // corrupt fill reads as a full node
            if (len == 0 || len > NODE_BYTES)
                len = NODE_BYTES;
            for (int i = 0; i < len; i++)
                post_result(ST_READ, pool_bytes[int'(n) * NODE_BYTES + i],
                            i == len - 1, len);
            append_node(FREE_LIST, n);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            clear_lists();
            pending <= 0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                cmd_count++;
                run_queue_command(cmd);
            end
            if (res_valid && !res_stall)
            begin
                result_count++;
                if (res.status == ST_READ)
                    byte_count++;
                if (res.status == ST_DROP)
                    drop_count++;
                if (due_results.size() == 0)
                begin
                    $error("unexpected result transfer: status %0d data %0h",
                           res.status, res.data_out);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (res.status != want.status)
                    begin
                        $error("status: expected %0d actual %0d", want.status, res.status);
                        fail_count++;
                    end
                    if (res.data_out != want.data_out)
                    begin
                        $error("data_out: expected %0h actual %0h",
                               want.data_out, res.data_out);
                        fail_count++;
                    end
                    if (res.last_out != want.last_out)
                    begin
                        $error("last_out: expected %0d actual %0d",
                               want.last_out, res.last_out);
                        fail_count++;
                    end
                    if (res.node_length != want.node_length)
                    begin
                        $error("node_length: expected %0d actual %0d",
                               want.node_length, res.node_length);
                        fail_count++;
                    end
                end
            end
            pending <= due_results.size();
        end
    end

endmodule

// ===== test/linked_list_multi_queue_buffer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_list_multi_queue_buffer_test
// Drives write and read commands into the linked-list queue buffer: a
// directed pass over bad ids, empty reads, queue switches and open nodes,
// a full node read back under receiver stalls, then a pool exhaustion pass
// with dropped bursts under a long receiver hold-off. Checking is done by
// the result checker instantiated beside the block.
// ----------------------------------------------------------------------------
module linked_list_multi_queue_buffer_test;

    import llmq_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 400;

    logic clk;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;

    int   fail_count;
    int   results_pending;
    int   cmd_count;
    int   result_count;
    int   byte_count;
    int   drop_count;

    int   idle_pct   = 0;
    int   stall_pct  = 0;
    int   hold_asks  = 0;
    int   cycle_count;

    linked_list_multi_queue_buffer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    llmq_result_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .res          (res),
        .fail_count   (fail_count),
        .pending      (results_pending),
        .cmd_count    (cmd_count),
        .result_count (result_count),
        .byte_count   (byte_count),
        .drop_count   (drop_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("end of test: mismatches");
        $finish;
    end

    // result side: random stalls plus long hold-offs on request
    initial
    begin
        int stall_left;
        int hold_served;
        stall_left  = 0;
        hold_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_served)
            begin
                hold_served = hold_asks;
                stall_left  = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                res_stall <= 1'b1;
                stall_left--;
            end
            else
                res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic set_mode(input int m);
        unique case (m)
            0:
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            1:
            begin
                idle_pct  = 76;
                stall_pct = 0;
            end
            2:
            begin
                idle_pct  = 0;
                stall_pct = 76;
            end
            default:
            begin
                idle_pct  = 10;
                stall_pct = 10;
            end
        endcase
    endtask

    task automatic send_cmd(input opcode_t op, input int q, input logic [7:0] d,
                            input logic last);
        cmd_t c;
        c.opcode   = op;
        c.queue_id = QID_W'(q);
        c.data_in  = d;
        c.last_in  = last;
        if ($urandom_range(99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    task automatic read_queue(input int q);
        send_cmd(OP_READ, q, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic write_burst(input int q, input int len, input bit closed);
        for (int i = 0; i < len; i++)
            send_cmd(OP_WRITE, q, 8'($urandom_range(255)), closed && i == len - 1);
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: bad ids, empty reads, open nodes and queue switches
        set_mode(0);
        send_cmd(OP_WRITE, 0, 8'h5A, 1'b0);
        send_cmd(OP_READ, 7, 8'h00, 1'b1);
        read_queue(1);
        send_cmd(OP_WRITE, 1, 8'h00, 1'b0);
        send_cmd(OP_WRITE, 1, 8'hFF, 1'b1);
        read_queue(1);
        send_cmd(OP_WRITE, 2, 8'hA5, 1'b0);
        read_queue(2);
        send_cmd(OP_READ, 0, 8'hFF, 1'b0);
        send_cmd(OP_WRITE, 3, 8'h3C, 1'b1);
        read_queue(4);
        send_cmd(OP_WRITE, 5, 8'h81, 1'b0);
        read_queue(6);
        read_queue(2);
        read_queue(5);
        read_queue(3);
        send_cmd(OP_WRITE, 6, 8'h7E, 1'b1);
        send_cmd(OP_READ, 6, 8'hFF, 1'b1);
        wait_drained();

        // node fills up and a second one starts; read back under stalls
        set_mode(1);
        write_burst(4, 66, 1'b1);
        set_mode(2);
        read_queue(4);
        read_queue(4);
        read_queue(4);
        wait_drained();

        // pool exhaustion: one-byte nodes round robin, long receiver hold-off
        set_mode(3);
        hold_asks++;
        for (int i = 0; i < NODE_COUNT; i++)
            send_cmd(OP_WRITE, (i % 6) + 1, 8'($urandom_range(255)), 1'b1);
        send_cmd(OP_WRITE, 3, 8'($urandom_range(255)), 1'b0);
        send_cmd(OP_WRITE, 3, 8'($urandom_range(255)), 1'b0);
        send_cmd(OP_WRITE, 3, 8'($urandom_range(255)), 1'b1);
        send_cmd(OP_WRITE, 2, 8'($urandom_range(255)), 1'b0);
        send_cmd(OP_WRITE, 4, 8'($urandom_range(255)), 1'b0);
        read_queue(4);
        send_cmd(OP_WRITE, 1, 8'($urandom_range(255)), 1'b1);
        send_cmd(OP_WRITE, 1, 8'($urandom_range(255)), 1'b1);
        for (int q = 1; q < LIST_COUNT; q++)
            read_queue(q);
        wait_drained();

        repeat (20) @(posedge clk);
        $display("run covered %0d commands and %0d checked results", cmd_count,
                 result_count);
        $display("  including %0d bytes read back and %0d dropped writes", byte_count,
                 drop_count);
        if (fail_count == 0 && results_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
